/* src/rse_pkg.sv */
// ----------------------------------------------------------------------------
// Radix symbol encoder package
// Shared widths, register indexes, the job descriptor and the digit helpers.
// ----------------------------------------------------------------------------
package rse_pkg;

    localparam int MAX_DIGITS_DEF = 64;
    localparam int SYMBOL_BITS    = 7;
    localparam int SYM_W          = 7;
    localparam int DIGIT_W        = 6;
    localparam int RADIX_W        = 6;
    localparam int VALUE_W        = 64;
    localparam int PAD_W          = 7;
    localparam int CNT_W          = 7;
    localparam int WORD_W         = 63;
    localparam int NUM_WORDS      = 7;
    localparam int ALPHA_W        = NUM_WORDS * WORD_W;
    localparam int ALPHA_EXT_W    = (1 << DIGIT_W) * SYMBOL_BITS + SYM_W;
    localparam int IDX_W          = 3;

    localparam logic [IDX_W-1:0]   REG_RADIX       = 3'd0;
    localparam logic [IDX_W-1:0]   REG_ALPHA_FIRST = 3'd1;
    localparam logic [RADIX_W-1:0] RADIX_MIN       = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_RESET     = 6'd2;
    localparam logic [WORD_W-1:0]  ALPHA0_RESET    = 63'd6320;

    typedef struct packed {
        logic             bank;
        logic             err;
        logic [CNT_W-1:0] ndig;
        logic [CNT_W-1:0] total;
    } desc_t;

    typedef struct packed {
        logic [7:0]         quot;
        logic [DIGIT_W-1:0] rem;
    } div_step_t;

    // One byte of long division by the radix, one restoring step per bit.
    function automatic div_step_t div_byte(input logic [DIGIT_W-1:0] rem_in,
                                           input logic [7:0]         data_in,
                                           input logic [RADIX_W-1:0] radix);
        div_step_t          res;
        logic [DIGIT_W:0]   r;
        r        = {1'b0, rem_in};
        res.quot = '0;
        for (int i = 7; i >= 0; i--) begin
            r = {r[DIGIT_W-1:0], data_in[i]};
            if (r >= {1'b0, radix}) begin
                r           = r - {1'b0, radix};
                res.quot[i] = 1'b1;
            end
        end
        res.rem = r[DIGIT_W-1:0];
        return res;
    endfunction

    // Symbols past the alphabet storage read as zero.
    function automatic logic [SYM_W-1:0] sym_lookup(input logic [ALPHA_W-1:0] alpha,
                                                    input logic [DIGIT_W-1:0] idx);
        logic [ALPHA_EXT_W-1:0] ext;
        ext = ALPHA_EXT_W'(alpha);
        return ext[int'(idx) * SYMBOL_BITS +: SYM_W];
    endfunction

endpackage

/* src/rse_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/rse_queue.sv */
// ----------------------------------------------------------------------------
// Job queue
// Two-entry FIFO of job descriptors between the digit front end and the
// symbol back end.
// ----------------------------------------------------------------------------
module rse_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  rse_pkg::desc_t push_desc,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output rse_pkg::desc_t head_desc
);

    rse_pkg::desc_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_desc  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                mem_reg[wr_ptr_reg] <= push_desc;
                wr_ptr_reg          <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* src/rse_front.sv */
// ----------------------------------------------------------------------------
// Digit front end
// Accepts a value, peels off base-radix digits least significant first by
// byte-wise long division, stores them in the digit RAM and posts a job.
// ----------------------------------------------------------------------------
module rse_front #(
    parameter int MAX_DIGITS = rse_pkg::MAX_DIGITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [rse_pkg::VALUE_W-1:0]           s_number_in,
    input  logic [rse_pkg::PAD_W-1:0]             s_pad_length,
    input  logic [rse_pkg::RADIX_W-1:0]           radix,
    input  logic                                  q_full,
    output logic                                  q_push,
    output rse_pkg::desc_t                        q_desc,
    output logic                                  ram_wr_en,
    output logic [$clog2(MAX_DIGITS):0]           ram_wr_addr,
    output logic [rse_pkg::DIGIT_W-1:0]           ram_wr_data
);

    localparam int DIG_AW = $clog2(MAX_DIGITS);
    localparam logic [rse_pkg::CNT_W-1:0] MAX_CNT = rse_pkg::CNT_W'(MAX_DIGITS);

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } state_t;

    state_t                          state_reg;
    logic [rse_pkg::VALUE_W-1:0]     val_reg;
    logic [2:0]                      top_reg;
    logic [2:0]                      bi_reg;
    logic [rse_pkg::DIGIT_W-1:0]     rem_reg;
    logic [rse_pkg::CNT_W-1:0]       ndig_reg;
    logic [rse_pkg::CNT_W-1:0]       pad_reg;
    logic [rse_pkg::CNT_W-1:0]       limit_reg;
    logic [rse_pkg::RADIX_W-1:0]     radix_reg;
    logic                            bank_reg;

    logic                            accept;
    rse_pkg::div_step_t              step;
    logic [rse_pkg::VALUE_W-1:0]     val_upd;
    logic                            digit_done;
    logic                            overflow;
    logic                            finish;
    logic [rse_pkg::CNT_W-1:0]       ndig_inc;
    logic [rse_pkg::CNT_W-1:0]       pad_sat;
    logic [2:0]                      top_in;
    logic [2:0]                      top_next;

    assign s_ready = (state_reg == ST_IDLE) && !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pad_sat = (s_pad_length > MAX_CNT) ? MAX_CNT : s_pad_length;
        top_in  = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (s_number_in[i*8 +: 8] != 8'd0) begin
                top_in = 3'(i);
            end
        end
    end

    always_comb begin
        step    = rse_pkg::div_byte(rem_reg, val_reg[{bi_reg, 3'b000} +: 8], radix_reg);
        val_upd = val_reg;
        val_upd[{bi_reg, 3'b000} +: 8] = step.quot;
        top_next = top_reg;
        if (top_reg != 3'd0 && val_upd[{top_reg, 3'b000} +: 8] == 8'd0) begin
            top_next = top_reg - 3'd1;
        end
    end

    assign digit_done = (state_reg == ST_DIV) && (bi_reg == 3'd0);
    // One digit more than the limit allows means the value does not fit.
    assign overflow   = ndig_reg == limit_reg;
    assign finish     = digit_done && (overflow || val_upd == '0);
    assign ndig_inc   = ndig_reg + rse_pkg::CNT_W'(1);

    assign ram_wr_en   = digit_done && !overflow;
    assign ram_wr_addr = {bank_reg, ndig_reg[DIG_AW-1:0]};
    assign ram_wr_data = step.rem;

    assign q_push     = finish;
    assign q_desc.bank  = bank_reg;
    assign q_desc.err   = overflow;
    assign q_desc.ndig  = ndig_inc;
    assign q_desc.total = (pad_reg != '0) ? pad_reg : ndig_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            bank_reg  <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        val_reg   <= s_number_in;
                        top_reg   <= top_in;
                        bi_reg    <= top_in;
                        rem_reg   <= '0;
                        ndig_reg  <= '0;
                        pad_reg   <= pad_sat;
                        limit_reg <= (pad_sat == '0) ? MAX_CNT : pad_sat;
                        radix_reg <= (radix < rse_pkg::RADIX_MIN) ? rse_pkg::RADIX_MIN : radix;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    val_reg <= val_upd;
                    if (bi_reg != 3'd0) begin
                        bi_reg  <= bi_reg - 3'd1;
                        rem_reg <= step.rem;
                    end else if (finish) begin
                        bank_reg  <= ~bank_reg;
                        state_reg <= ST_IDLE;
                    end else begin
                        // start the next digit on the shrunken quotient
                        ndig_reg <= ndig_inc;
                        top_reg  <= top_next;
                        bi_reg   <= top_next;
                        rem_reg  <= '0;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/rse_back.sv */
// ----------------------------------------------------------------------------
// Symbol back end
// Takes jobs from the queue, reads digits most significant first, inserts
// pad symbols and maps digits through the alphabet to output symbols.
// ----------------------------------------------------------------------------
module rse_back #(
    parameter int MAX_DIGITS = rse_pkg::MAX_DIGITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    input  rse_pkg::desc_t                    q_desc,
    output logic                              q_pop,
    output logic [$clog2(MAX_DIGITS):0]       ram_rd_addr,
    input  logic [rse_pkg::DIGIT_W-1:0]       ram_rd_data,
    input  logic [rse_pkg::ALPHA_W-1:0]       alpha,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rse_pkg::SYM_W-1:0]         m_symbol_out,
    output logic                              m_last_symbol,
    output logic                              m_too_long
);

    localparam int DIG_AW = $clog2(MAX_DIGITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_HOLD
    } state_t;

    state_t                      state_reg;
    logic [rse_pkg::CNT_W-1:0]   pos_reg;
    logic                        pad_reg;
    logic [rse_pkg::SYM_W-1:0]   sym_reg;
    logic                        last_reg;
    logic                        err_reg;
    logic [rse_pkg::DIGIT_W-1:0] digit;

    assign ram_rd_addr = {q_desc.bank, pos_reg[DIG_AW-1:0]};
    assign digit       = pad_reg ? '0 : ram_rd_data;

    assign m_valid       = state_reg == ST_HOLD;
    assign m_symbol_out  = sym_reg;
    assign m_last_symbol = last_reg;
    assign m_too_long    = err_reg;
    assign q_pop         = (state_reg == ST_HOLD) && m_ready && last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        if (q_desc.err) begin
                            sym_reg   <= '0;
                            last_reg  <= 1'b1;
                            err_reg   <= 1'b1;
                            state_reg <= ST_HOLD;
                        end else begin
                            pos_reg   <= q_desc.total - rse_pkg::CNT_W'(1);
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH: begin
                    // positions above the top digit take the pad symbol
                    pad_reg   <= pos_reg >= q_desc.ndig;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    sym_reg   <= rse_pkg::sym_lookup(alpha, digit);
                    last_reg  <= pos_reg == '0;
                    err_reg   <= 1'b0;
                    state_reg <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (m_ready) begin
                        if (last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            pos_reg   <= pos_reg - rse_pkg::CNT_W'(1);
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/radix_symbol_encoder.sv */
// Flow: the front end divides one significant byte of the running quotient
// per cycle for each digit, dropping quotient bytes that have become zero; the
// back end then fetches, loads and holds each symbol in turn (FETCH, LOAD, HOLD).
// Throughput: set by the slower of the byte-serial divider and the back end;
// the two-entry job queue and a two-bank digit RAM let them overlap.
// Reset: radix 2, alphabet '0' and '1', queue empty; digit RAM is not cleared.
// ----------------------------------------------------------------------------
// Radix symbol encoder
// Writes a 64-bit value in a configurable base as a padded string of
// alphabet symbols, most significant digit first.
// ----------------------------------------------------------------------------
module radix_symbol_encoder #(
    parameter int MAX_DIGITS = rse_pkg::MAX_DIGITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [rse_pkg::VALUE_W-1:0]     s_number_in,
    input  logic [rse_pkg::PAD_W-1:0]       s_pad_length,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rse_pkg::SYM_W-1:0]       m_symbol_out,
    output logic                            m_last_symbol,
    output logic                            m_too_long,
    input  logic                            cfg_wr_en,
    input  logic [rse_pkg::IDX_W-1:0]       cfg_index,
    input  logic [rse_pkg::WORD_W-1:0]      cfg_wdata
);

    localparam int DIG_AW    = $clog2(MAX_DIGITS);
    localparam int RAM_DEPTH = 2 << DIG_AW;

    logic [rse_pkg::RADIX_W-1:0] radix_reg;
    logic [rse_pkg::WORD_W-1:0]  alpha_reg [rse_pkg::NUM_WORDS];
    logic [rse_pkg::ALPHA_W-1:0] alpha_flat;
    logic [rse_pkg::IDX_W-1:0]   word_sel;

    logic                        q_full;
    logic                        q_push;
    rse_pkg::desc_t              q_push_desc;
    logic                        q_pop;
    logic                        q_valid;
    rse_pkg::desc_t              q_head;

    logic                        ram_wr_en;
    logic [DIG_AW:0]             ram_wr_addr;
    logic [rse_pkg::DIGIT_W-1:0] ram_wr_data;
    logic [DIG_AW:0]             ram_rd_addr;
    logic [rse_pkg::DIGIT_W-1:0] ram_rd_data;

    assign word_sel = cfg_index - rse_pkg::REG_ALPHA_FIRST;

    always_comb begin
        for (int i = 0; i < rse_pkg::NUM_WORDS; i++) begin
            alpha_flat[i*rse_pkg::WORD_W +: rse_pkg::WORD_W] = alpha_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= rse_pkg::RADIX_RESET;
            for (int i = 0; i < rse_pkg::NUM_WORDS; i++) begin
                alpha_reg[i] <= '0;
            end
            alpha_reg[0] <= rse_pkg::ALPHA0_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == rse_pkg::REG_RADIX) begin
                radix_reg <= cfg_wdata[rse_pkg::RADIX_W-1:0];
            end else if (int'(word_sel) < rse_pkg::NUM_WORDS) begin
                alpha_reg[word_sel] <= cfg_wdata;
            end
        end
    end

    rse_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_number_in  (s_number_in),
        .s_pad_length (s_pad_length),
        .radix        (radix_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_desc       (q_push_desc),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data)
    );

    rse_ram #(
        .WIDTH (rse_pkg::DIGIT_W),
        .DEPTH (RAM_DEPTH)
    ) u_digit_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    rse_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_desc  (q_push_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_desc  (q_head)
    );

    rse_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_desc        (q_head),
        .q_pop         (q_pop),
        .ram_rd_addr   (ram_rd_addr),
        .ram_rd_data   (ram_rd_data),
        .alpha         (alpha_flat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_symbol_out  (m_symbol_out),
        .m_last_symbol (m_last_symbol),
        .m_too_long    (m_too_long)
    );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radix symbol encoder testbench
// Feeds values and pad lengths through the encoder under a series of radix
// and alphabet settings. Every symbol transfer is checked against a digit
// predictor that runs beside the block. Both ports see random stalls.
// ----------------------------------------------------------------------------
module testbench;
    import rse_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 400;
    localparam int PHASE_ITEMS   = 42;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [PAD_W-1:0]   pad;
    } number_job_t;

    typedef struct {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             too_long;
    } sym_result_t;

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [VALUE_W-1:0]   s_number_in   = '0;
    logic [PAD_W-1:0]     s_pad_length  = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [SYM_W-1:0]     m_symbol_out;
    logic                 m_last_symbol;
    logic                 m_too_long;
    logic                 cfg_wr_en     = 1'b0;
    logic [IDX_W-1:0]     cfg_index     = '0;
    logic [WORD_W-1:0]    cfg_wdata     = '0;

    // Copy of the block's registers, updated from the write port itself
    logic [RADIX_W-1:0]   radix_shadow;
    logic [WORD_W-1:0]    alphabet_shadow [NUM_WORDS];

    number_job_t          pending_numbers [$];
    sym_result_t          expected_symbols [$];
    number_job_t          next_job;
    sym_result_t          want;

    logic                 in_taken      = 1'b0;
    logic                 idle_on       = 1'b1;
    int                   src_gap       = 0;
    int                   sink_gap      = 0;
    int                   hold_left     = 0;
    int                   holds_requested = 0;
    int                   holds_done    = 0;
    int                   quiet_cycles  = 0;
    int                   mismatches    = 0;
    int                   values_sent   = 0;
    int                   symbols_checked = 0;
    int                   errors_seen   = 0;
    int                   settings_used = 1;

    radix_symbol_encoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_number_in   (s_number_in),
        .s_pad_length  (s_pad_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_symbol_out  (m_symbol_out),
        .m_last_symbol (m_last_symbol),
        .m_too_long    (m_too_long),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Split a value into base digits, least significant first; returns the count.
    function automatic int split_digits(input logic [VALUE_W-1:0] value,
                                        input logic [RADIX_W-1:0] radix_reg,
                                        output logic [DIGIT_W-1:0] digits [64]);
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] rest;
        int                 n;
        base = (radix_reg < RADIX_MIN) ? VALUE_W'(RADIX_MIN) : VALUE_W'(radix_reg);
        rest = value;
        n    = 0;
        do begin
            if (n < 64) digits[n] = DIGIT_W'(rest % base);
            n++;
            rest = rest / base;
        end while (rest != 0);
        return n;
    endfunction

    function automatic logic [SYM_W-1:0] symbol_at(input int idx);
        logic [ALPHA_W-1:0] flat;
        logic [SYM_W-1:0]   sym;
        int                 p;
        for (int w = 0; w < NUM_WORDS; w++) flat[w*WORD_W +: WORD_W] = alphabet_shadow[w];
        sym = '0;
        for (int b = 0; b < SYMBOL_BITS; b++) begin
            p = idx * SYMBOL_BITS + b;
            if (p < ALPHA_W && b < SYM_W) sym[b] = flat[p];
        end
        return sym;
    endfunction

    function automatic void predict_symbols(input logic [VALUE_W-1:0] value,
                                            input logic [PAD_W-1:0]   pad_in);
        logic [DIGIT_W-1:0] digits [64];
        sym_result_t        r;
        int                 n;
        int                 pad;
        int                 total;
        int                 pos;
        n   = split_digits(value, radix_shadow, digits);
        pad = (int'(pad_in) > MAX_DIGITS_DEF) ? MAX_DIGITS_DEF : int'(pad_in);
        if (n > MAX_DIGITS_DEF || (pad != 0 && n > pad)) begin
            r.symbol   = '0;
            r.last     = 1'b1;
            r.too_long = 1'b1;
            expected_symbols.insert(expected_symbols.size(), r);
            return;
        end
        total = (pad != 0) ? pad : n;
        for (int k = 0; k < total; k++) begin
            pos        = total - 1 - k;
            r.symbol   = (pos >= n) ? symbol_at(0) : symbol_at(int'(digits[pos]));
            r.last     = (k + 1 == total);
            r.too_long = 1'b0;
            expected_symbols.insert(expected_symbols.size(), r);
        end
    endfunction

    function automatic void queue_job(input logic [VALUE_W-1:0] value,
                                      input logic [PAD_W-1:0]   pad);
        number_job_t j;
        j.value = value;
        j.pad   = pad;
        pending_numbers.insert(pending_numbers.size(), j);
    endfunction

    // Mostly well-fitted pad lengths, with some short, saturating and random ones.
    function automatic void queue_random_job();
        logic [DIGIT_W-1:0] digits [64];
        logic [VALUE_W-1:0] value;
        int                 width;
        int                 n;
        int                 pad;
        value = {$urandom, $urandom};
        width = $urandom_range(1, 64);
        if (width < 64) value = value & ((64'd1 << width) - 64'd1);
        case ($urandom_range(0, 15))
            0:       value = '0;
            1:       value = '1;
            default: ;
        endcase
        n = split_digits(value, radix_shadow, digits);
        case ($urandom_range(0, 9))
            0, 1, 2: pad = 0;
            3, 4, 5: pad = n + $urandom_range(0, 4);
            6:       pad = n - 1;
            7:       pad = $urandom_range(0, 127);
            8:       pad = $urandom_range(65, 127);
            default: pad = n;
        endcase
        if (pad > MAX_DIGITS_DEF && pad <= MAX_DIGITS_DEF + 4) pad = MAX_DIGITS_DEF;
        queue_job(value, PAD_W'(pad));
    endfunction

    function automatic logic [ALPHA_W-1:0] pack_symbols(input string chars);
        logic [ALPHA_W-1:0] v;
        byte                c;
        v = '0;
        for (int i = 0; i < chars.len(); i++) begin
            c = chars[i];
            v[i*SYMBOL_BITS +: SYMBOL_BITS] = c[6:0];
        end
        return v;
    endfunction

    function automatic logic [ALPHA_W-1:0] random_alphabet();
        logic [ALPHA_W-1:0] v;
        logic [63:0]        r;
        for (int w = 0; w < NUM_WORDS; w++) begin
            r = {$urandom, $urandom};
            v[w*WORD_W +: WORD_W] = r[WORD_W-1:0];
        end
        return v;
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
    endtask

    // Upper data bits above the radix field are junk and must be dropped.
    task automatic configure(input logic [RADIX_W-1:0] radix, input logic [ALPHA_W-1:0] alpha);
        logic [WORD_W-1:0] junk;
        junk = WORD_W'({$urandom, $urandom});
        write_reg(REG_RADIX, {junk[WORD_W-1:RADIX_W], radix});
        for (int w = 0; w < NUM_WORDS; w++)
            write_reg(REG_ALPHA_FIRST + IDX_W'(w), alpha[w*WORD_W +: WORD_W]);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        while (pending_numbers.size() != 0 || s_valid || expected_symbols.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic run_phase(input logic [RADIX_W-1:0] radix, input logic [ALPHA_W-1:0] alpha);
        wait_idle();
        configure(radix, alpha);
        for (int i = 0; i < PHASE_ITEMS; i++) queue_random_job();
    endtask

    // Sender: hold each transfer until accepted, insert short gaps between them
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (src_gap > 0) begin
                s_valid <= 1'b0;
                src_gap = src_gap - 1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                s_valid <= 1'b0;
                src_gap = $urandom_range(0, 2);
            end else if (pending_numbers.size() > 0) begin
                next_job = pending_numbers.pop_front();
                s_valid      <= 1'b1;
                s_number_in  <= next_job.value;
                s_pad_length <= next_job.pad;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: short random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (holds_done < holds_requested) begin
            m_ready <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
            holds_done++;
        end else if (sink_gap > 0) begin
            m_ready <= 1'b0;
            sink_gap = sink_gap - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_ready <= 1'b0;
            sink_gap = $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        in_taken = 1'b0;
        if (!aresetn) begin
            radix_shadow = RADIX_RESET;
            for (int w = 0; w < NUM_WORDS; w++) alphabet_shadow[w] = '0;
            alphabet_shadow[0] = ALPHA0_RESET;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_symbols.size() == 0) begin
                    $display("%0t: unexpected symbol transfer: expected none actual %h/%b/%b",
                             $time, m_symbol_out, m_last_symbol, m_too_long);
                    mismatches++;
                end else begin
                    want = expected_symbols.pop_front();
                    if (m_symbol_out !== want.symbol) begin
                        $display("%0t: symbol_out mismatch: expected %h actual %h",
                                 $time, want.symbol, m_symbol_out);
                        mismatches++;
                    end
                    if (m_last_symbol !== want.last) begin
                        $display("%0t: last_symbol mismatch: expected %b actual %b",
                                 $time, want.last, m_last_symbol);
                        mismatches++;
                    end
                    if (m_too_long !== want.too_long) begin
                        $display("%0t: too_long mismatch: expected %b actual %b",
                                 $time, want.too_long, m_too_long);
                        mismatches++;
                    end
                    if (want.too_long) errors_seen++;
                end
                symbols_checked++;
            end
            if (s_valid && s_ready) begin
                predict_symbols(s_number_in, s_pad_length);
                in_taken = 1'b1;
                values_sent++;
            end
            if (cfg_wr_en) begin
                if (cfg_index == REG_RADIX)
                    radix_shadow = cfg_wdata[RADIX_W-1:0];
                else
                    alphabet_shadow[cfg_index - REG_ALPHA_FIRST] = cfg_wdata;
            end
            if ((m_valid && m_ready) || in_taken || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d symbols outstanding",
                         $time, quiet_cycles, expected_symbols.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: binary with '0' and '1'
        queue_job(64'd0, 7'd0);
        queue_job(64'd0, 7'd1);
        queue_job(64'd0, 7'd64);
        queue_job(64'd1, 7'd0);
        queue_job('1, 7'd0);
        queue_job('1, 7'd64);
        queue_job('1, 7'd63);
        queue_job(64'h8000_0000_0000_0000, 7'd0);
        queue_job(64'd5, 7'd2);
        queue_job(64'd5, 7'd3);
        queue_job(64'd1, 7'd127);
        queue_job(64'd6, 7'd65);
        queue_job(64'h5555_5555_5555_5555, 7'd0);
        queue_job(64'hAAAA_AAAA_AAAA_AAAA, 7'd100);

        // Widest base: the top digit and a carry into a second digit
        wait_idle();
        configure(6'd63, random_alphabet());
        queue_job(64'd62, 7'd0);
        queue_job(64'd63, 7'd0);
        queue_job(64'd0, 7'd64);
        queue_job('1, 7'd0);
        queue_job('1, 7'd10);
        queue_job('1, 7'd11);

        // Radix of zero or one falls back to binary
        wait_idle();
        configure(6'd0, pack_symbols("ab"));
        queue_job(64'd6, 7'd0);
        queue_job(64'd6, 7'd3);
        wait_idle();
        configure(6'd1, '0);
        queue_job(64'd9, 7'd0);
        queue_job(64'd0, 7'd2);

        run_phase(6'd10, pack_symbols("0123456789"));
        run_phase(6'd16, pack_symbols("0123456789abcdef"));
        // Stall the result side long enough to back up the input
        @(posedge aclk);
        holds_requested++;
        run_phase(RADIX_W'($urandom_range(2, 63)), random_alphabet());
        run_phase(6'd63, '1);

        wait_idle();
        @(posedge aclk);
        idle_on = 1'b0;
        run_phase(RADIX_W'($urandom_range(2, 63)), random_alphabet());

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Encoded %0d values into %0d checked symbols (%0d overflow results)",
                 values_sent, symbols_checked, errors_seen);
        $display("across %0d register settings, bases 0 to 63, with a long output stall",
                 settings_used);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
src/rse_pkg.sv
src/rse_ram.sv
src/rse_queue.sv
src/rse_front.sv
src/rse_back.sv
src/radix_symbol_encoder.sv
tb/testbench.sv
